[hdl/sacp_pkg.sv]
// Package: shared constants and types for the prefetching set-associative cache.
`default_nettype none
package sacp_pkg;
    localparam int SETS_DEF         = 256;
    localparam int WAYS_DEF         = 8;
    localparam int ADDR_WIDTH_DEF   = 32;
    localparam int PREFETCH_MAX_DEF = 15;
    localparam int STAMP_W          = 48;
    localparam int TAG_W            = 32;
    localparam int CNT_W            = 32;

    localparam logic [2:0] REG_OFFSET   = 3'd0;
    localparam logic [2:0] REG_INDEX    = 3'd1;
    localparam logic [2:0] REG_WAYS     = 3'd2;
    localparam logic [2:0] REG_PREFETCH = 3'd3;
    localparam logic [2:0] REG_LRU      = 3'd4;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_BLOCK  = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_NEXT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;
endpackage
`default_nettype wire

[hdl/set_assoc_cache_with_prefetch.sv]
// Top level: write-through set-associative cache model with next-line prefetch.
// Flow: each block walked passes BLOCK, then READ and CHECK per way read, then WRITE and
//   NEXT. A hit ends the walk after the first block; a miss walks up to prefetch_count+1
//   blocks (clamped values) before OUT. One request at a time; the next is taken in the
//   cycle after the result is accepted.
// Reset: a clearing pass zeroes the valid bits of all SETS*WAYS entries one by one; no request is
//   taken until it ends. Counters, stamp clock and registers reset to defaults.
`default_nettype none
module set_assoc_cache_with_prefetch
    import sacp_pkg::*;
#(
    parameter int SETS         = SETS_DEF,
    parameter int WAYS         = WAYS_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
    parameter int PREFETCH_MAX = PREFETCH_MAX_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [3:0]            i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_opcode,
    input  wire logic [31:0]           i_address,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_hit,
    output logic [4:0]                 o_lines_fetched,
    output logic [CNT_W-1:0]           o_total_hits,
    output logic [CNT_W-1:0]           o_total_misses,
    output logic [CNT_W-1:0]           o_total_reads,
    output logic [CNT_W-1:0]           o_total_writes
);
    localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DEPTH  = SETS * WAYS;
    localparam int EW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WCW    = $clog2(WAYS + 1);
    localparam int PW     = $clog2(PREFETCH_MAX + 2);
    localparam int AW     = ADDR_WIDTH;

    // Configuration registers
    logic [3:0] r_offset_bits, r_index_bits, r_ways_in_use, r_prefetch_count;
    logic       r_lru_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits    <= 4'd6;
            r_index_bits     <= 4'd4;
            r_ways_in_use    <= 4'd1;
            r_prefetch_count <= 4'd0;
            r_lru_mode       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OFFSET:   r_offset_bits    <= i_cfg_data;
                REG_INDEX:    r_index_bits     <= i_cfg_data;
                REG_WAYS:     r_ways_in_use    <= i_cfg_data;
                REG_PREFETCH: r_prefetch_count <= i_cfg_data;
                REG_LRU:      r_lru_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective (clamped) geometry
    logic [3:0]     eff_off, eff_idx;
    logic [WCW-1:0] eff_ways;
    logic [PW-1:0]  eff_extra;
    always_comb begin
        eff_off = (r_offset_bits > 4'd12) ? 4'd12 : r_offset_bits;
        eff_idx = (r_index_bits > 4'd8) ? 4'd8 : r_index_bits;
        if (r_ways_in_use == 4'd0)
            eff_ways = WCW'(1);
        else if (32'(r_ways_in_use) > WAYS)
            eff_ways = WCW'(WAYS);
        else
            eff_ways = WCW'(r_ways_in_use);
        if (32'(r_prefetch_count) > PREFETCH_MAX)
            eff_extra = PW'(PREFETCH_MAX);
        else
            eff_extra = PW'(r_prefetch_count);
    end

    // Memories: tag and stamp; valid bits cleared by a sweep
    logic [TAG_W-1:0]   m_tag   [DEPTH];
    logic [STAMP_W-1:0] m_stamp [DEPTH];
    logic               m_valid [DEPTH];

    t_state r_state, n_state;
    logic [AW-1:0]      r_cur;
    logic               r_hit, r_lookup;
    logic [PW-1:0]      r_blk;
    logic [WCW-1:0]     r_way;
    logic [WW-1:0]      r_victim;
    logic               r_free;
    logic [STAMP_W-1:0] r_least;
    logic [STAMP_W-1:0] r_stamp_ctr;
    logic [EW:0]        r_clr;
    logic [4:0]         r_fetched;
    logic [CNT_W-1:0]   r_hits, r_misses, r_reads, r_writes;
    logic               r_found;
    logic [WW-1:0]      r_found_way;
    logic [TAG_W-1:0]   rd_tag;
    logic [STAMP_W-1:0] rd_stamp;
    logic               rd_valid;

    // Address decode for current block; tag shift can reach 20, so sum in 5 bits
    logic [AW-1:0]    idx_full;
    logic [SW-1:0]    cur_set;
    logic [TAG_W-1:0] cur_tag;
    logic [AW-1:0]    tag_full;
    always_comb begin
        idx_full = (r_cur >> eff_off) & ((AW'(1) << eff_idx) - AW'(1));
        cur_set  = SW'(idx_full % SETS);
        tag_full = r_cur >> (5'(eff_off) + 5'(eff_idx));
        cur_tag  = TAG_W'(tag_full);
    end

    logic [EW-1:0] rd_addr, wr_addr;
    logic [WW-1:0] wr_way;
    assign wr_way  = r_found ? r_found_way : r_victim;
    assign rd_addr = EW'(32'(cur_set) * WAYS + 32'(r_way[WW-1:0]));
    assign wr_addr = EW'(32'(cur_set) * WAYS + 32'(wr_way));

    logic do_fill, do_touch;
    assign do_fill  = (r_state == S_WRITE) && !r_found;
    assign do_touch = (r_state == S_WRITE) && r_found && r_lookup && r_lru_mode;

    // Ways read one at a time (READ, then CHECK); write at the end of a block
    always_ff @(posedge i_clk) begin
        rd_tag   <= m_tag[rd_addr];
        rd_stamp <= m_stamp[rd_addr];
        rd_valid <= m_valid[rd_addr];
        if (r_state == S_CLEAR)
            m_valid[r_clr[EW-1:0]] <= 1'b0;
        else if (do_fill)
            m_valid[wr_addr] <= 1'b1;
        if (do_fill)
            m_tag[wr_addr] <= cur_tag;
        if (do_fill || do_touch)
            m_stamp[wr_addr] <= r_stamp_ctr;
    end

    // Sequencer
    logic last_way;
    assign last_way = (r_way + WCW'(1)) >= eff_ways;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (32'(r_clr) == DEPTH - 1) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_BLOCK;
            S_BLOCK: n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (rd_valid && rd_tag == cur_tag) n_state = S_WRITE;
                else if (last_way) n_state = S_WRITE;
                else n_state = S_READ;
            end
            S_WRITE: n_state = S_NEXT;
            S_NEXT: begin
                if (r_hit || r_blk == eff_extra) n_state = S_OUT;
                else n_state = S_BLOCK;
            end
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_stamp_ctr <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (i_valid) begin
                    r_cur     <= AW'(i_address);
                    r_blk     <= '0;
                    r_fetched <= '0;
                    r_hit     <= 1'b0;
                    r_lookup  <= 1'b1;
                    if (i_opcode == OP_WRITE) r_writes <= r_writes + 1'b1;
                end
                S_BLOCK: begin
                    r_way    <= '0;
                    r_found  <= 1'b0;
                    r_free   <= 1'b0;
                    r_victim <= '0;
                    r_least  <= r_stamp_ctr;
                end
                S_CHECK: begin
                    if (rd_valid && rd_tag == cur_tag) begin
                        r_found     <= 1'b1;
                        r_found_way <= r_way[WW-1:0];
                    end else if (!rd_valid) begin
                        if (!r_free) begin
                            r_free   <= 1'b1;
                            r_victim <= r_way[WW-1:0];
                        end
                    end else if (!r_free && rd_stamp < r_least) begin
                        r_least  <= rd_stamp;
                        r_victim <= r_way[WW-1:0];
                    end
                    r_way <= r_way + WCW'(1);
                end
                S_WRITE: begin
                    if (r_lookup) begin
                        if (r_found) begin
                            r_hit  <= 1'b1;
                            r_hits <= r_hits + 1'b1;
                        end else
                            r_misses <= r_misses + 1'b1;
                    end
                    if (do_fill || do_touch)
                        r_stamp_ctr <= r_stamp_ctr + 1'b1;
                    if (do_fill) begin
                        r_reads   <= r_reads + 1'b1;
                        r_fetched <= r_fetched + 5'd1;
                    end
                end
                S_NEXT: begin
                    r_lookup <= 1'b0;
                    r_blk    <= r_blk + PW'(1);
                    r_cur    <= r_cur + (AW'(1) << eff_off);
                end
                default: ;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_hit           = r_hit;
    assign o_lines_fetched = r_fetched;
    assign o_total_hits    = r_hits;
    assign o_total_misses  = r_misses;
    assign o_total_reads   = r_reads;
    assign o_total_writes  = r_writes;

    // Checks
    a_hit_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_lines_fetched == 5'd0)
        else $error("hit with fetches");
    a_miss_fetch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_lines_fetched <= 5'(eff_extra) + 5'd1)
        else $error("too many fetches");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");
    a_hits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_hits != $past(r_hits) |-> r_hits == $past(r_hits) + 1'b1)
        else $error("hit count jump");
endmodule
`default_nettype wire
